>>> rtl/modular_exponentiation_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define MODEXP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that a condition never holds outside reset.
`define MODEXP_NEVER(label, cond, msg) \
   `MODEXP_ASSERT(label, !(cond), msg)

`endif

>>> rtl/modexp_pkg.sv
package modexp_pkg;

   // Default operand width of the base, modulus, exponent and result.
   localparam int OPERAND_BITS = 32;

   // Reset values of the configuration registers.
   localparam int MODULUS_RESET  = 3233;
   localparam int EXPONENT_RESET = 17;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODULUS  = 1'b0,
      CSR_EXPONENT = 1'b1
   } csr_index_type;

endpackage

>>> rtl/modular_exponentiation.sv
// Modular exponentiation core: rsp_power_result = req_base_value ** exponent mod modulus.
// Configuration: csr_write_enable, csr_index and csr_write_data load the modulus
// (index 0, reset 3233) and the exponent (index 1, reset 17); write them only while
// busy is low.
// Input: an item is accepted at a clock edge where start is high and busy is low.
// Output: rsp_valid pulses for one cycle with rsp_power_result; the receiver cannot
// stall, so the result must be taken in that cycle.
// Sequence: a zero exponent or a modulus below two gives its result in the cycle
// after acceptance. Otherwise the base is first reduced modulo the modulus, then the
// exponent is scanned from its least significant bit with one shared modular
// multiplier. Each multiplication follows a dispatch step, then doubles once for
// every multiplier bit and adds the multiplicand for every set bit. At most
// 2 * OPERAND_BITS - 1 multiplications are needed. Scanning stops after the highest
// set exponent bit.
// busy stays high from acceptance through the result cycle; one item at a time.
// Reset is synchronous: it returns to idle and reloads the register reset values.
module modular_exponentiation #(
   parameter int OPERAND_BITS = modexp_pkg::OPERAND_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [OPERAND_BITS-1:0]             req_base_value,
   output logic                                rsp_valid,
   output logic [OPERAND_BITS-1:0]             rsp_power_result,
   input  logic                                csr_write_enable,
   input  logic [modexp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [OPERAND_BITS-1:0]             csr_write_data
);

   localparam int W        = OPERAND_BITS;
   localparam int CNT_BITS = $clog2(W);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_REDUCE  = 6'b000010,
      ST_SELECT  = 6'b000100,
      ST_MUL_DBL = 6'b001000,
      ST_MUL_ADD = 6'b010000,
      ST_FINISH  = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [W-1:0]          modulus_ff, exponent_ff;
   logic [W-1:0]          acc_ff, acc_in;
   logic [W-1:0]          b_sh_ff, b_sh_in;
   logic [W-1:0]          res_ff, res_in;
   logic [W-1:0]          sq_ff, sq_in;
   logic [W-1:0]          exp_sh_ff, exp_sh_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  sq_phase_ff, sq_phase_in;
   logic                  dest_res_ff, dest_res_in;

   logic [W-1:0]          add_x, add_y, a_val, mod_sum;
   logic                  add_cin;
   logic [W:0]            sum, diff;
   logic                  advance, last_bit;

   // Multiplicand: the running result when updating it, else the square.
   assign a_val    = dest_res_ff ? res_ff : sq_ff;
   assign last_bit = (cnt_ff == CNT_BITS'(W - 1));

   // Shared modular adder: (x + y + cin) mod modulus, inputs below the modulus.
   always_comb begin
      add_x   = acc_ff;
      add_y   = (state_ff == ST_MUL_ADD) ? a_val : acc_ff;
      add_cin = (state_ff == ST_REDUCE) ? b_sh_ff[W-1] : 1'b0;
      sum     = {1'b0, add_x} + {1'b0, add_y} + {{W{1'b0}}, add_cin};
      diff    = sum - {1'b0, modulus_ff};
      mod_sum = (sum >= {1'b0, modulus_ff}) ? diff[W-1:0] : sum[W-1:0];
   end

   // Sequencer: reduce the base, then square-and-multiply one bit per step.
   always_comb begin
      state_in    = state_ff;
      acc_in      = acc_ff;
      b_sh_in     = b_sh_ff;
      res_in      = res_ff;
      sq_in       = sq_ff;
      exp_sh_in   = exp_sh_ff;
      cnt_in      = cnt_ff;
      sq_phase_in = sq_phase_ff;
      dest_res_in = dest_res_ff;
      advance     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               b_sh_in     = req_base_value;
               acc_in      = '0;
               cnt_in      = '0;
               exp_sh_in   = exponent_ff;
               sq_phase_in = 1'b0;
               if (exponent_ff == '0) begin
                  res_in   = W'(1);
                  state_in = ST_FINISH;
               end else if (modulus_ff < W'(2)) begin
                  res_in   = '0;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            // Restoring remainder: shift in one base bit per cycle.
            acc_in  = mod_sum;
            b_sh_in = {b_sh_ff[W-2:0], 1'b0};
            cnt_in  = cnt_ff + CNT_BITS'(1);
            if (last_bit) begin
               cnt_in   = '0;
               sq_in    = mod_sum;
               res_in   = W'(1);
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            if (exp_sh_ff == '0) begin
               state_in = ST_FINISH;
            end else if (sq_phase_ff && (exp_sh_ff[W-1:1] == '0)) begin
               // No higher exponent bits remain, so the last square is not needed.
               state_in = ST_FINISH;
            end else begin
               acc_in      = '0;
               cnt_in      = '0;
               b_sh_in     = sq_ff;
               dest_res_in = !sq_phase_ff && exp_sh_ff[0];
               state_in    = ST_MUL_DBL;
            end
         end
         ST_MUL_DBL: begin
            acc_in = mod_sum;
            if (b_sh_ff[W-1]) begin
               state_in = ST_MUL_ADD;
            end else begin
               advance = 1'b1;
            end
         end
         ST_MUL_ADD: begin
            acc_in  = mod_sum;
            advance = 1'b1;
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Move to the next multiplier bit; write back after the last one.
      if (advance) begin
         b_sh_in  = {b_sh_ff[W-2:0], 1'b0};
         cnt_in   = cnt_ff + CNT_BITS'(1);
         state_in = ST_MUL_DBL;
         if (last_bit) begin
            state_in = ST_SELECT;
            if (dest_res_ff) begin
               res_in      = mod_sum;
               sq_phase_in = 1'b1;
            end else begin
               sq_in       = mod_sum;
               exp_sh_in   = {1'b0, exp_sh_ff[W-1:1]};
               sq_phase_in = 1'b0;
            end
         end
      end
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         modulus_ff  <= W'(modexp_pkg::MODULUS_RESET);
         exponent_ff <= W'(modexp_pkg::EXPONENT_RESET);
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            case (modexp_pkg::csr_index_type'(csr_index))
               modexp_pkg::CSR_MODULUS:  modulus_ff  <= csr_write_data;
               modexp_pkg::CSR_EXPONENT: exponent_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   // Datapath shift registers and counters.
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      b_sh_ff     <= b_sh_in;
      res_ff      <= res_in;
      sq_ff       <= sq_in;
      exp_sh_ff   <= exp_sh_in;
      cnt_ff      <= cnt_in;
      sq_phase_ff <= sq_phase_in;
      dest_res_ff <= dest_res_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_FINISH);
   assign rsp_power_result = res_ff;

endmodule

>>> rtl/modexp_checker.sv
`include "modular_exponentiation_assert.svh"

// Port-level checks of the command handshake and the result strobe.
module modexp_checker #(
   parameter int OPERAND_BITS = modexp_pkg::OPERAND_BITS
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_valid,
   input logic [OPERAND_BITS-1:0]             rsp_power_result
);

   // A result only appears while an item is in flight.
   `MODEXP_NEVER(a_rsp_needs_busy, rsp_valid && !busy, "result strobe while idle")

   // The result strobe lasts a single cycle.
   `MODEXP_ASSERT(a_rsp_one_cycle, rsp_valid |=> !rsp_valid, "result strobe held")

   // An accepted item makes the block busy in the next cycle.
   `MODEXP_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted item not busy")

   // The block goes idle only right after delivering its result.
   `MODEXP_ASSERT(a_idle_after_rsp, $fell(busy) |-> $past(rsp_valid), "idle without result")

   // A strobed result carries a fully known value.
   `MODEXP_ASSERT(a_rsp_known, rsp_valid |-> !$isunknown(rsp_power_result), "unknown result")

endmodule

bind modular_exponentiation modexp_checker #(.OPERAND_BITS(OPERAND_BITS)) u_checker (.*);
